FILE: rtl/eal_pkg.sv
package eal_pkg;

    localparam int ECHO_W        = 21;
    localparam int CFG_W         = 16;
    localparam int CFG_ADDR_W    = 2;
    localparam int AVG_W         = 16;
    localparam int DIST_W        = 16;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 40;
    localparam int DEF_READINGS  = 10;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_TANK_DEPTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ECHO_TMO    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_RATIO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OVF_MARGIN  = 2'd3;

    localparam logic [CFG_W-1:0] RST_TANK_DEPTH  = 16'd3000;
    localparam logic [CFG_W-1:0] RST_ECHO_TMO    = 16'd24125;
    localparam logic [CFG_W-1:0] RST_SPEED_RATIO = 16'd11358;
    localparam logic [CFG_W-1:0] RST_OVF_MARGIN  = 16'd50;

    // ceil(2^17 / 3), exact floor(x / 3) for any 16-bit x
    localparam logic [16:0] RECIP_3    = 17'd43691;
    localparam int          RECIP_3_SH = 17;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

FILE: rtl/eal_accum.sv
module eal_accum #(
    parameter int READINGS_PER_BATCH = eal_pkg::DEF_READINGS,
    parameter int CNT_W              = 4,
    parameter int SUM_W              = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [eal_pkg::ECHO_W-1:0] echo_time_us,
    input  logic [eal_pkg::CFG_W-1:0] echo_timeout_us,
    output logic                      batch_end,
    output logic [SUM_W-1:0]          batch_sum,
    output logic [CNT_W-1:0]          batch_count
);

    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] index_reg;
    logic             echo_ok;

    assign echo_ok = (echo_time_us != '0) &&
                     (echo_time_us < eal_pkg::ECHO_W'(echo_timeout_us));

    assign batch_sum   = sum_reg + (echo_ok ? SUM_W'(echo_time_us) : '0);
    assign batch_count = count_reg + (echo_ok ? CNT_W'(1) : '0);
    assign batch_end   = accept && (index_reg == CNT_W'(READINGS_PER_BATCH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            index_reg <= '0;
        end
        else if (accept)
        begin
            if (batch_end)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                index_reg <= '0;
            end
            else
            begin
                sum_reg   <= batch_sum;
                count_reg <= batch_count;
                index_reg <= index_reg + CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/eal_div.sv
module eal_div #(
    parameter int CNT_W = 4,
    parameter int SUM_W = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [SUM_W-1:0]            dividend,
    input  logic [CNT_W-1:0]            divisor,
    output eal_pkg::unit_stat_t         stat,
    output logic [eal_pkg::AVG_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    // the average never exceeds the largest valid echo, so 16 bits hold it
    assign quotient  = dvd_reg[eal_pkg::AVG_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/eal_mul.sv
module eal_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [eal_pkg::AVG_W-1:0]    mplr,
    input  logic [eal_pkg::CFG_W-1:0]    mcand,
    output eal_pkg::unit_stat_t          stat,
    output logic [eal_pkg::DIST_W-1:0]   product_hi
);

    localparam int AW     = eal_pkg::AVG_W;
    localparam int BW     = eal_pkg::CFG_W;
    localparam int STEP_W = $clog2(AW + 1);

    logic [AW+BW-1:0]  acc_reg;
    logic [AW-1:0]     mplr_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [BW:0]       part;

    // shift-add from the lsb of the multiplier, one bit per cycle
    assign part = {1'b0, acc_reg[AW+BW-1:AW]} + (mplr_reg[0] ? {1'b0, mcand} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(AW);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= '0;
            mplr_reg <= mplr;
        end
        else if (busy_reg)
        begin
            acc_reg  <= {part, acc_reg[AW-1:1]};
            mplr_reg <= {1'b0, mplr_reg[AW-1:1]};
        end
    end

    assign product_hi = acc_reg[AW+BW-1:AW+BW-eal_pkg::DIST_W];
    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;

endmodule

FILE: rtl/echo_average_level_classifier_unit.sv
// echo average level classifier
// input stream: one echo time in us per item in s_axis_tdata; every
// READINGS_PER_BATCH items form a batch. output stream: one result item per
// batch on m_axis_tdata. registers are written through cfg_we/cfg_addr/cfg_wdata
// with no wait; the user must write them only while the block is idle (not enforced).
// items that do not close a batch leave s_axis_tready high.
// the item closing a batch starts a bit-serial restoring divider (sum width =
// 16 + count width bits, 20 for a batch of ten) and then a bit-serial
// shift-add multiplier over the 16-bit average; a finish state then computes
// level and flags into the output register before the next item is taken.
// a batch with no valid echo skips both units: the closing item moves the
// sequencer straight to the finish state, which loads the error result; input
// resumes in the same cycle that the result becomes valid.
// reset clears the batch accumulator, the sequencer and the output valid and
// loads the register defaults.
// the output register lets a new batch be taken while a result waits; if the
// receiver still stalls when the next result is finished, the block holds that
// result and stops taking items until the waiting one is taken.
module echo_average_level_classifier_unit #(
    parameter int READINGS_PER_BATCH = eal_pkg::DEF_READINGS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [20:0] echo_time_us, [23:21] zero
    input  logic [eal_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] reading_ok, [16:1] distance_mm, [32:17] level_mm, [33] low_flag,
    // [34] overflow, [39:35] zero
    output logic [eal_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                 cfg_we,
    input  logic [eal_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [eal_pkg::CFG_W-1:0]            cfg_wdata
);

    localparam int CNT_W = $clog2(READINGS_PER_BATCH + 1);
    localparam int SUM_W = eal_pkg::AVG_W + CNT_W;
    localparam int DW    = eal_pkg::DIST_W;

    logic [eal_pkg::CFG_W-1:0] depth_reg;
    logic [eal_pkg::CFG_W-1:0] timeout_reg;
    logic [eal_pkg::CFG_W-1:0] ratio_reg;
    logic [eal_pkg::CFG_W-1:0] margin_reg;

    eal_pkg::state_t state_reg;
    eal_pkg::state_t state_next;

    logic                       in_accept;
    logic                       batch_end;
    logic [SUM_W-1:0]           batch_sum;
    logic [CNT_W-1:0]           batch_count;
    logic                       err_reg;
    logic                       div_start;
    logic                       mul_start;
    eal_pkg::unit_stat_t        div_stat;
    eal_pkg::unit_stat_t        mul_stat;
    logic [eal_pkg::AVG_W-1:0]  avg;
    logic [DW-1:0]              dist_mm;
    logic [DW-1:0]              third_reg;
    logic [eal_pkg::CFG_W+16:0] third_prod;
    logic                       out_load;
    logic                       out_valid_reg;
    logic                       ok_reg;
    logic [DW-1:0]              dist_reg;
    logic [DW-1:0]              level_reg;
    logic                       low_reg;
    logic                       ovf_reg;

    assign s_axis_tready = (state_reg == eal_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign div_start     = batch_end && (batch_count != '0);
    assign mul_start     = (state_reg == eal_pkg::ST_DIV) && div_stat.done;
    assign out_load      = (state_reg == eal_pkg::ST_FIN) &&
                           (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= eal_pkg::RST_TANK_DEPTH;
            timeout_reg <= eal_pkg::RST_ECHO_TMO;
            ratio_reg   <= eal_pkg::RST_SPEED_RATIO;
            margin_reg  <= eal_pkg::RST_OVF_MARGIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                eal_pkg::REG_TANK_DEPTH:  depth_reg   <= cfg_wdata;
                eal_pkg::REG_ECHO_TMO:    timeout_reg <= cfg_wdata;
                eal_pkg::REG_SPEED_RATIO: ratio_reg   <= cfg_wdata;
                eal_pkg::REG_OVF_MARGIN:  margin_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    eal_accum #(
        .READINGS_PER_BATCH (READINGS_PER_BATCH),
        .CNT_W              (CNT_W),
        .SUM_W              (SUM_W)
    ) u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (in_accept),
        .echo_time_us    (s_axis_tdata[eal_pkg::ECHO_W-1:0]),
        .echo_timeout_us (timeout_reg),
        .batch_end       (batch_end),
        .batch_sum       (batch_sum),
        .batch_count     (batch_count)
    );

    eal_div #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (batch_sum),
        .divisor  (batch_count),
        .stat     (div_stat),
        .quotient (avg)
    );

    eal_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mul_start),
        .mplr       (avg),
        .mcand      (ratio_reg),
        .stat       (mul_stat),
        .product_hi (dist_mm)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eal_pkg::ST_IDLE:
            begin
                if (batch_end)
                    state_next = div_start ? eal_pkg::ST_DIV : eal_pkg::ST_FIN;
            end
            eal_pkg::ST_DIV:
            begin
                if (div_stat.done)
                    state_next = eal_pkg::ST_MUL;
            end
            eal_pkg::ST_MUL:
            begin
                if (mul_stat.done)
                    state_next = eal_pkg::ST_FIN;
            end
            eal_pkg::ST_FIN:
            begin
                if (out_load)
                    state_next = eal_pkg::ST_IDLE;
            end
            default: state_next = eal_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eal_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // floor(depth / 3) by reciprocal; the user must keep config steady while a batch is finishing (not enforced)
    assign third_prod = depth_reg * eal_pkg::RECIP_3;

    always_ff @(posedge clk)
    begin
        third_reg <= third_prod[eal_pkg::RECIP_3_SH +: DW];
        if (batch_end)
            err_reg <= (batch_count == '0);
        if (out_load)
        begin
            if (err_reg)
            begin
                ok_reg    <= 1'b0;
                dist_reg  <= '0;
                level_reg <= '0;
                low_reg   <= 1'b1;
                ovf_reg   <= 1'b1;
            end
            else
            begin
                ok_reg    <= 1'b1;
                dist_reg  <= dist_mm;
                level_reg <= (depth_reg > dist_mm) ? (depth_reg - dist_mm) : '0;
                low_reg   <= {1'b0, dist_mm} > {third_reg, 1'b0};
                ovf_reg   <= dist_mm < margin_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, ovf_reg, low_reg, level_reg, dist_reg, ok_reg};

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_stat.busy && mul_stat.busy))
        else $error("divider and multiplier busy together");

    a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!div_stat.busy && !mul_stat.busy))
        else $error("item taken while a unit is busy");

    a_mul_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |=> (state_reg == eal_pkg::ST_FIN))
        else $error("multiplier result not finished");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ok_reg) |->
            (low_reg && ovf_reg && (dist_reg == '0) && (level_reg == '0)))
        else $error("error result malformed");

endmodule

FILE: tb/tb_echo_average_level_classifier_unit.sv
`timescale 1ns / 1ps
module tb_echo_average_level_classifier_unit;

    localparam int BATCH        = eal_pkg::DEF_READINGS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 50;
    localparam int LONG_HOLD    = 400;
    localparam int ECHO_MAX     = (1 << eal_pkg::ECHO_W) - 1;

    typedef struct {
        logic                       ok;
        logic [eal_pkg::DIST_W-1:0] dist_mm;
        logic [eal_pkg::CFG_W-1:0]  level;
        logic                       low;
        logic                       ovf;
    } level_report_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // [20:0] echo_time_us, [23:21] zero
    logic [eal_pkg::IN_TDATA_W-1:0]      s_axis_tdata = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // [0] reading_ok, [16:1] distance_mm, [32:17] level_mm, [33] low_flag,
    // [34] overflow, [39:35] zero
    logic [eal_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                                cfg_we = 1'b0;
    logic [eal_pkg::CFG_ADDR_W-1:0]      cfg_addr = '0;
    logic [eal_pkg::CFG_W-1:0]           cfg_wdata = '0;

    // predictor state
    logic [eal_pkg::CFG_W-1:0] depth_q  = eal_pkg::RST_TANK_DEPTH;
    logic [eal_pkg::CFG_W-1:0] tmo_q    = eal_pkg::RST_ECHO_TMO;
    logic [eal_pkg::CFG_W-1:0] ratio_q  = eal_pkg::RST_SPEED_RATIO;
    logic [eal_pkg::CFG_W-1:0] margin_q = eal_pkg::RST_OVF_MARGIN;
    logic [21:0]      echo_sum_q = '0;
    logic [6:0]       valid_cnt_q = '0;
    logic [6:0]       echo_idx_q = '0;
    level_report_t    pending_reports[$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_max = 0;
    int burst_max = 1;
    int stall_pct = 0;
    int rdy_run = 0;
    logic rdy_state = 1'b1;
    logic hold_active = 1'b0;
    event hold_go;

    echo_average_level_classifier_unit #(
        .READINGS_PER_BATCH(BATCH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // fold one accepted echo into the batch, queue the report when it closes
    function automatic void absorb_echo(input logic [eal_pkg::ECHO_W-1:0] echo);
        level_report_t    rep;
        logic [21:0]      avg;
        longint unsigned  prod;
        logic [16:0]      thresh;
        if (echo != 0 && echo < tmo_q)
        begin
            echo_sum_q  = echo_sum_q + echo;
            valid_cnt_q = valid_cnt_q + 7'd1;
        end
        echo_idx_q = echo_idx_q + 7'd1;
        if (echo_idx_q < BATCH)
            return;
        if (valid_cnt_q == 0)
        begin
            rep.ok = 1'b0;
            rep.dist_mm = '0;
            rep.level = '0;
            rep.low = 1'b1;
            rep.ovf = 1'b1;
        end
        else
        begin
            avg = echo_sum_q / valid_cnt_q;
            prod = longint'(avg) * longint'(ratio_q);
            rep.ok = 1'b1;
            rep.dist_mm = prod[31:16];
            rep.level = (depth_q > rep.dist_mm) ? depth_q - rep.dist_mm : '0;
            thresh = 17'((depth_q / 3) * 2);
            rep.low = (rep.dist_mm > thresh);
            rep.ovf = (rep.dist_mm < margin_q);
        end
        pending_reports.push_back(rep);
        echo_sum_q = '0;
        valid_cnt_q = '0;
        echo_idx_q = '0;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what,
                 want, got);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        level_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_reports.size() == 0)
                report_mismatch("unexpected result item", 0, m_axis_tdata);
            else
            begin
                want = pending_reports.pop_front();
                if (m_axis_tdata[0] !== want.ok)
                    report_mismatch("reading_ok", want.ok, m_axis_tdata[0]);
                if (m_axis_tdata[16:1] !== want.dist_mm)
                    report_mismatch("distance_mm", want.dist_mm, m_axis_tdata[16:1]);
                if (m_axis_tdata[32:17] !== want.level)
                    report_mismatch("level_mm", want.level, m_axis_tdata[32:17]);
                if (m_axis_tdata[33] !== want.low)
                    report_mismatch("low_flag", want.low, m_axis_tdata[33]);
                if (m_axis_tdata[34] !== want.ovf)
                    report_mismatch("overflow", want.ovf, m_axis_tdata[34]);
            end
        end
    end

    // result side: runs of ready/stall, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_active)
            m_axis_tready <= 1'b0;
        else
        begin
            if (rdy_run == 0)
            begin
                rdy_state = ($urandom_range(0, 99) >= stall_pct);
                rdy_run = $urandom_range(1, 6);
            end
            rdy_run--;
            m_axis_tready <= rdy_state;
        end
    end

    initial
    begin
        forever
        begin
            @(hold_go);
            hold_active = 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    task automatic send_echo(input logic [eal_pkg::ECHO_W-1:0] echo);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(eal_pkg::IN_TDATA_W-eal_pkg::ECHO_W){1'b0}}, echo};
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        absorb_echo(echo);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [eal_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [eal_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            eal_pkg::REG_TANK_DEPTH:  depth_q = val;
            eal_pkg::REG_ECHO_TMO:    tmo_q = val;
            eal_pkg::REG_SPEED_RATIO: ratio_q = val;
            eal_pkg::REG_OVF_MARGIN:  margin_q = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int depth, input int tmo, input int ratio,
                                  input int margin);
        wait_idle();
        write_reg(eal_pkg::REG_TANK_DEPTH, eal_pkg::CFG_W'(depth));
        write_reg(eal_pkg::REG_ECHO_TMO, eal_pkg::CFG_W'(tmo));
        write_reg(eal_pkg::REG_SPEED_RATIO, eal_pkg::CFG_W'(ratio));
        write_reg(eal_pkg::REG_OVF_MARGIN, eal_pkg::CFG_W'(margin));
    endtask

    function automatic logic [eal_pkg::ECHO_W-1:0] pick_echo();
        int r;
        int t;
        r = $urandom_range(0, 99);
        t = tmo_q;
        if (r < 70 && t > 1)
            return eal_pkg::ECHO_W'($urandom_range(1, t - 1));
        else if (r < 78)
            return '0;
        else if (r < 86)
            return eal_pkg::ECHO_W'($urandom_range(t, 65535));
        else if (r < 94)
            return eal_pkg::ECHO_W'($urandom_range(0, ECHO_MAX));
        else if (r < 97 && t > 0)
            return eal_pkg::ECHO_W'(t - 1);
        else
            return eal_pkg::ECHO_W'(t);
    endfunction

    function automatic logic [eal_pkg::ECHO_W-1:0] pick_rejected();
        if ($urandom_range(0, 1))
            return '0;
        return eal_pkg::ECHO_W'($urandom_range(int'(tmo_q), ECHO_MAX));
    endfunction

    task automatic send_random_batch();
        int kind;
        int lone;
        kind = $urandom_range(0, 99);
        lone = $urandom_range(0, BATCH - 1);
        for (int i = 0; i < BATCH; i++)
        begin
            if (kind < 5)
                send_echo(pick_rejected());
            else if (kind < 12)
                send_echo((i == lone && tmo_q > 1)
                          ? eal_pkg::ECHO_W'($urandom_range(1, tmo_q - 1))
                          : pick_rejected());
            else
                send_echo(pick_echo());
        end
    endtask

    task automatic run_random_phase(input int depth, input int tmo, input int ratio,
                                    input int margin, input int batches, input int gmax,
                                    input int bmax, input int spct);
        apply_settings(depth, tmo, ratio, margin);
        gap_max = gmax;
        burst_max = bmax;
        stall_pct = spct;
        repeat (batches) send_random_batch();
    endtask

    // defaults after reset, echo field extremes and the timeout edge
    task automatic test_extremes_defaults();
        logic [eal_pkg::ECHO_W-1:0] echoes[BATCH];
        echoes = '{0, 1, ECHO_MAX, 24124, 24125, 24126, 21'h155555, 21'h0AAAAA,
                   5800, 12345};
        gap_max = 2;
        burst_max = 4;
        stall_pct = 20;
        foreach (echoes[i]) send_echo(echoes[i]);
    endtask

    // a batch with nothing valid reports the error pattern
    task automatic test_no_valid_echo();
        logic [eal_pkg::ECHO_W-1:0] echoes[BATCH];
        echoes = '{0, 24125, 65535, 0, ECHO_MAX, 0, 30000, 24125, 0, 1048576};
        foreach (echoes[i]) send_echo(echoes[i]);
    endtask

    // distance beyond the tank depth clamps the level at zero
    task automatic test_level_clamp();
        apply_settings(100, 24125, 11358, 65535);
        for (int i = 0; i < BATCH; i++)
            send_echo(i == 3 ? '0 : eal_pkg::ECHO_W'(10000));
    endtask

    task automatic test_random_traffic();
        run_random_phase(eal_pkg::RST_TANK_DEPTH, eal_pkg::RST_ECHO_TMO,
                         eal_pkg::RST_SPEED_RATIO, eal_pkg::RST_OVF_MARGIN,
                         20, 4, 6, 30);
        // everything at maximum, no idling on either side
        run_random_phase(65535, 65535, 65535, 65535, 20, 0, 1, 0);
        // zero timeout: every batch is an error
        run_random_phase(0, 0, 0, 0, 10, 3, 5, 50);
        run_random_phase(1, 1, 1, 1, 8, 1, 8, 10);
        run_random_phase($urandom_range(0, 65535), 65535, 0, 1, 10, 6, 3, 70);
        repeat (5)
            run_random_phase($urandom_range(0, 65535), $urandom_range(1, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 8000),
                             20, $urandom_range(0, 8), $urandom_range(1, 12),
                             $urandom_range(0, 80));
    endtask

    // receiver holds off while items keep coming, so the block has to stall its input
    task automatic test_backpressure_fill();
        apply_settings(eal_pkg::RST_TANK_DEPTH, eal_pkg::RST_ECHO_TMO,
                       eal_pkg::RST_SPEED_RATIO, eal_pkg::RST_OVF_MARGIN);
        gap_max = 0;
        burst_max = 1;
        stall_pct = 0;
        -> hold_go;
        repeat (4) send_random_batch();
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes_defaults();
        test_no_valid_echo();
        test_level_clamp();
        test_random_traffic();
        test_backpressure_fill();
        wait_idle();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/eal_pkg.sv
rtl/eal_accum.sv
rtl/eal_div.sv
rtl/eal_mul.sv
rtl/echo_average_level_classifier_unit.sv
tb/tb_echo_average_level_classifier_unit.sv
